// ===== hw/rtl/ccb_pkg.sv =====
// Shared types, constants and a helper function for the circular capture buffer.
package ccb_pkg;

    localparam int DEPTH    = 64;
    localparam int SAMPLE_W = 32;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int LEN_W    = PTR_W + 1;
    localparam int DVS_W    = LEN_W + PTR_W - 1;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 7;
    localparam int RCNT_W   = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_APPEND   = 2'd0,
        FUNC_READ_FWD = 2'd1,
        FUNC_READ_REV = 2'd2,
        FUNC_RESTART  = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [DATA_W-1:0]  sample_value;
        logic [RCNT_W-1:0]  read_count;
        logic               read_whole;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]  out_value;
        logic               last_of_burst;
        logic [CNT_W-1:0]   points_written;
    } t_out_item;

    // RAM port requests from the sequencer
    typedef struct packed {
        logic                we;
        logic [PTR_W-1:0]    waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic                re;
        logic [PTR_W-1:0]    raddr;
    } t_ram_req;

    // Output queue status back to the sequencer
    typedef struct packed {
        logic [1:0] level;
        logic       pop;
    } t_q_stat;

    // Register value to ring length in use: zero acts as one, clipped at DEPTH
    function automatic logic [LEN_W-1:0] f_active_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] len;
        if (v == '0) begin
            len = LEN_W'(1);
        end else if (32'(v) > 32'(DEPTH)) begin
            len = LEN_W'(DEPTH);
        end else begin
            len = LEN_W'(v);
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/circular_capture_buffer.sv =====
// Circular capture buffer: ring of samples with append, burst read and restart.
//
// Input channel (i_in_valid / o_in_stall) carries one command per transfer:
// append stores sample_value at the write pointer, a forward read returns
// read_count samples from the write pointer onward (oldest first), a reverse
// read returns the newest samples first, restart moves the write pointer to
// the read pointer and clears the sample count. read_whole reads the whole
// ring; read_count is capped at the ring length.
// i_cfg_we / i_cfg_wdata set the ring length (0 acts as 1, above 64 as 64);
// write it only while the block is idle. Both pointers are then reduced into
// the new length in state ST_MOD with the input stalled; samples are kept.
// Append and restart do not stall the input. A read of n samples holds the
// input stalled after its transfer until its n RAM reads are issued, one per
// cycle while the output queue has room; each result passes through the RAM
// read register and the output queue. Results leave through a two-entry queue
// on o_out_valid / i_out_stall; when the receiver stalls, RAM reads pause
// once the queue and the read in flight would fill it, so nothing is lost.
// Reset returns length 1, pointers and count to zero, and marks every entry
// unwritten so it reads as zero; no clearing pass is needed.
module circular_capture_buffer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ccb_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  ccb_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ccb_pkg::t_out_item        o_out_data
);

    import ccb_pkg::*;

    t_ram_req            ram_req;
    logic [SAMPLE_W-1:0] rd_data;
    t_q_stat             q_stat;
    logic                push;
    t_out_item           push_item;

    ccb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    ccb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_ram_req   (ram_req),
        .i_rd_data   (rd_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_item (push_item)
    );

    ccb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_q_stat    (q_stat)
    );

endmodule

// ===== hw/rtl/ccb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ccb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ccb_ctrl.sv =====
// Sequencer: pointers, sample count, entry valid flags and read burst issue.
module ccb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccb_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ccb_pkg::t_in_item             i_in_data,
    output ccb_pkg::t_ram_req             o_ram_req,
    input  logic [ccb_pkg::SAMPLE_W-1:0]  i_rd_data,
    input  ccb_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output ccb_pkg::t_out_item            o_push_item
);

    import ccb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD
    } t_state;

    t_state           r_state;
    logic [LEN_W-1:0] r_len;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [DEPTH-1:0] r_vld;
    logic [PTR_W-1:0] r_idx;
    logic [LEN_W-1:0] r_left;
    logic             r_dir;
    logic             r_pend;
    logic             r_pend_hit;
    logic             r_pend_last;
    logic [CNT_W-1:0] r_pend_cnt;
    logic [DVS_W-1:0] r_dvs;

    logic             in_acc;
    logic             rd_issue;
    logic [2:0]       q_fill;
    logic [LEN_W-1:0] rd_n;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W:0]   fwd_sum;
    logic [PTR_W-1:0] fwd_end;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] wp_dec;
    logic [PTR_W-1:0] idx_inc;
    logic [PTR_W-1:0] idx_dec;
    logic [PTR_W-1:0] wp_red;
    logic [PTR_W-1:0] rp_red;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // entries already queued or in flight, less the one leaving this cycle
    always_comb begin
        q_fill = 3'(i_q_stat.level) + 3'(r_pend);
        if (i_q_stat.pop) begin
            q_fill = q_fill - 3'd1;
        end
    end

    assign rd_issue = (r_state == ST_READ) && (q_fill < 3'd2);

    always_comb begin
        if (i_in_data.read_whole) begin
            rd_n = r_len;
        end else if (32'(i_in_data.read_count) > 32'(r_len)) begin
            rd_n = r_len;
        end else begin
            rd_n = LEN_W'(i_in_data.read_count);
        end
    end

    always_comb begin
        fwd_sum = (LEN_W+1)'(r_wp) + (LEN_W+1)'(rd_n);
        if (fwd_sum >= (LEN_W+1)'(r_len)) begin
            fwd_sum = fwd_sum - (LEN_W+1)'(r_len);
        end
        fwd_end = PTR_W'(fwd_sum);
    end

    assign n_len   = f_active_len(i_cfg_wdata);
    assign wp_inc  = (LEN_W'(r_wp) + LEN_W'(1) == r_len) ? '0 : r_wp + PTR_W'(1);
    assign wp_dec  = (r_wp == '0) ? PTR_W'(r_len - LEN_W'(1)) : r_wp - PTR_W'(1);
    assign idx_inc = (LEN_W'(r_idx) + LEN_W'(1) == r_len) ? '0 : r_idx + PTR_W'(1);
    assign idx_dec = (r_idx == '0) ? PTR_W'(r_len - LEN_W'(1)) : r_idx - PTR_W'(1);

    // restoring remainder step: r_dvs is the new length shifted by the current bit
    assign wp_red  = (DVS_W'(r_wp) >= r_dvs) ? r_wp - PTR_W'(r_dvs) : r_wp;
    assign rp_red  = (DVS_W'(r_rp) >= r_dvs) ? r_rp - PTR_W'(r_dvs) : r_rp;

    always_comb begin
        o_ram_req.we    = in_acc && (i_in_data.func == FUNC_APPEND);
        o_ram_req.waddr = r_wp;
        o_ram_req.wdata = SAMPLE_W'(i_in_data.sample_value);
        o_ram_req.re    = rd_issue;
        o_ram_req.raddr = r_idx;
    end

    // entries never appended read as zero
    always_comb begin
        o_push                     = r_pend;
        o_push_item.out_value      = r_pend_hit ? DATA_W'(i_rd_data) : '0;
        o_push_item.last_of_burst  = r_pend_last;
        o_push_item.points_written = r_pend_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= LEN_W'(1);
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_vld   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= rd_issue;
            if (rd_issue) begin
                r_pend_hit  <= r_vld[r_idx];
                r_pend_last <= (r_left == LEN_W'(1));
                r_pend_cnt  <= r_cnt;
                r_idx       <= r_dir ? idx_dec : idx_inc;
                r_left      <= r_left - LEN_W'(1);
                if (r_left == LEN_W'(1)) begin
                    r_state <= ST_IDLE;
                end
            end
            if (i_cfg_we) begin
                r_len   <= n_len;
                r_dvs   <= DVS_W'(n_len) << (PTR_W - 1);
                r_state <= ST_MOD;
            end else if (r_state == ST_MOD) begin
                // one bit of the reduction per cycle on both pointers
                r_wp  <= wp_red;
                r_rp  <= rp_red;
                r_dvs <= r_dvs >> 1;
                if (r_dvs == DVS_W'(r_len)) begin
                    r_state <= ST_IDLE;
                end
            end else if (in_acc) begin
                case (i_in_data.func)
                    FUNC_APPEND: begin
                        r_vld[r_wp] <= 1'b1;
                        r_wp        <= wp_inc;
                        if (r_cnt != CNT_MAX) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                    FUNC_READ_FWD: begin
                        r_rp <= fwd_end;
                        if (rd_n != '0) begin
                            r_state <= ST_READ;
                            r_idx   <= r_wp;
                            r_left  <= rd_n;
                            r_dir   <= 1'b0;
                        end
                    end
                    FUNC_READ_REV: begin
                        r_rp <= r_wp;
                        if (rd_n != '0) begin
                            r_state <= ST_READ;
                            r_idx   <= wp_dec;
                            r_left  <= rd_n;
                            r_dir   <= 1'b1;
                        end
                    end
                    FUNC_RESTART: begin
                        r_wp  <= r_rp;
                        r_cnt <= '0;
                    end
                    default: begin
                        r_wp <= r_wp;
                    end
                endcase
            end
        end
    end

    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MOD) |-> ((LEN_W'(r_wp) < r_len) && (LEN_W'(r_rp) < r_len)))
        else $error("pointer outside active ring length");

    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_left != '0))
        else $error("read burst active with nothing left");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_issue && (r_left == LEN_W'(1))) |=> (r_state == ST_IDLE) && r_pend_last)
        else $error("burst did not close on its final read");

endmodule

// ===== hw/rtl/ccb_outq.sv =====
// Two-entry output queue decoupling RAM reads from the result receiver.
module ccb_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ccb_pkg::t_out_item  i_push_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ccb_pkg::t_out_item  o_out_data,
    output ccb_pkg::t_q_stat    o_q_stat
);

    import ccb_pkg::*;

    t_out_item  r_mem [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_level;
    logic       pop;

    assign o_out_valid = (r_level != 2'd0);
    assign o_out_data  = r_mem[r_head];
    assign pop         = o_out_valid && !i_out_stall;

    assign o_q_stat.level = r_level;
    assign o_q_stat.pop   = pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_item;
        end
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (i_push) begin
                r_tail <= ~r_tail;
            end
            if (pop) begin
                r_head <= ~r_head;
            end
            case ({i_push, pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && (r_level == 2'd2)) |-> pop)
        else $error("transfer pushed into a full output queue");

endmodule
